// File: rtl/core/leading_byte_truncation_encoder_defines.svh
// assertion macros for the leading byte truncation encoder
// no dependencies; taken in by `include where assertions are written
`ifndef LEADING_BYTE_TRUNCATION_ENCODER_DEFINES_SVH
`define LEADING_BYTE_TRUNCATION_ENCODER_DEFINES_SVH

// same-cycle implication, checked outside reset
`define LBTE_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define LBTE_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/lbte_pkg.sv
// shared types and constants of the leading byte truncation encoder
// no dependencies; used by lbte_encode and the top level
package lbte_pkg;

    localparam int CHUNK       = 32;
    localparam int POS_W       = $clog2(CHUNK);
    localparam int MAX_RESULTS = 5;
    localparam int RES_CNT_W   = 3;

    // position of the final sample of a chunk
    localparam logic [POS_W-1:0] POS_LAST = POS_W'(CHUNK - 1);

    typedef enum logic [1:0] {
        KIND_DATA    = 2'd0,
        KIND_COUNT   = 2'd1,
        KIND_RESIDUE = 2'd2
    } kind_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] data;
    } result_t;

    typedef result_t [MAX_RESULTS-1:0] result_list_t;

    typedef struct packed {
        logic [23:0]      prev_top;
        logic [POS_W-1:0] pos;
        logic [5:0]       count_acc;
        logic [6:0]       res_acc;
        logic [2:0]       res_fill;
    } state_t;

endpackage

// File: rtl/core/lbte_encode.sv
// single-pass encoder: turns one sample and the running state into its result list
// depends on lbte_pkg
module lbte_encode (
    input  logic [63:0]                       value_bits,
    input  logic signed [5:0]                 error_exponent,
    input  lbte_pkg::state_t                  state,
    output lbte_pkg::state_t                  state_next,
    output lbte_pkg::result_list_t            results,
    output logic [lbte_pkg::RES_CNT_W-1:0]    result_count
);

    logic signed [6:0] req_full;
    logic [4:0]        req;
    logic [1:0]        kb;
    logic [2:0]        rb;
    logic [23:0]       top;
    logic [2:0]        eq;
    logic [1:0]        same;
    logic [1:0]        cnt;

    logic [7:0]        res_src;
    logic [6:0]        res_bits;
    logic [13:0]       res_acc_wide;
    logic [3:0]        res_fill_sum;
    logic              res_emit;
    logic [7:0]        res_byte;
    logic [2:0]        res_fill_left;

    logic [1:0]        group;
    logic              chunk_end;
    logic [7:0]        cnt_acc;
    logic              cnt_emit;
    logic [7:0]        cnt_byte;
    logic [2:0]        cnt_shift;

    assign top = value_bits[63:40];
    assign eq  = {state.prev_top[7:0]   == top[7:0],
                  state.prev_top[15:8]  == top[15:8],
                  state.prev_top[23:16] == top[23:16]};

    always_comb begin
        req_full = 7'sd12 - $signed({error_exponent[5], error_exponent});
        if (req_full < 7'sd0) begin
            req = 5'd0;
        end else if (req_full > 7'sd31) begin
            req = 5'd31;
        end else begin
            req = req_full[4:0];
        end
        kb = req[4:3];
        rb = req[2:0];

        // leading kept bytes equal to the previous sample, none at chunk start
        same = 2'd0;
        if (state.pos != '0) begin
            if (kb >= 2'd1 && eq[0]) begin
                same = 2'd1;
                if (kb >= 2'd2 && eq[1]) begin
                    same = 2'd2;
                    if (kb == 2'd3 && eq[2]) begin
                        same = 2'd3;
                    end
                end
            end
        end
        cnt = kb - same;

        // residue bits come from the byte just below the kept bytes
        unique case (kb)
            2'd0:    res_src = top[23:16];
            2'd1:    res_src = top[15:8];
            2'd2:    res_src = top[7:0];
            default: res_src = value_bits[39:32];
        endcase
        res_bits      = 7'(res_src >> (4'd8 - {1'b0, rb}));
        res_acc_wide  = (14'(state.res_acc) << rb) | 14'(res_bits);
        res_fill_sum  = {1'b0, state.res_fill} + {1'b0, rb};
        res_emit      = (rb != 3'd0) && res_fill_sum[3];
        res_byte      = 8'(res_acc_wide >> (res_fill_sum - 4'd8));
        res_fill_left = res_fill_sum[2:0];

        group     = state.pos[1:0];
        chunk_end = state.pos == lbte_pkg::POS_LAST;
        cnt_acc   = {state.count_acc, cnt};
        cnt_emit  = (group == 2'd3) || chunk_end;
        cnt_shift = {2'd3 - group, 1'b0};
        cnt_byte  = cnt_acc << cnt_shift;

        state_next          = state;
        state_next.prev_top = top;
        state_next.pos      = chunk_end ? '0 : state.pos + 1'b1;
        state_next.count_acc = cnt_emit ? 6'd0 : cnt_acc[5:0];
        if (rb != 3'd0) begin
            state_next.res_fill = res_fill_left;
            if (res_emit) begin
                state_next.res_acc = res_acc_wide[6:0] & ((7'd1 << res_fill_left) - 7'd1);
            end else begin
                state_next.res_acc = res_acc_wide[6:0];
            end
        end

        result_count = {1'b0, cnt} + {2'b0, res_emit} + {2'b0, cnt_emit};
    end

    // order: differing kept bytes, then residue byte, then count byte
    always_comb begin : build_list
        logic [1:0] idx;
        for (int k = 0; k < lbte_pkg::MAX_RESULTS; k++) begin
            idx = same + 2'(k);
            if (3'(k) < {1'b0, cnt}) begin
                results[k].kind = lbte_pkg::KIND_DATA;
                unique case (idx)
                    2'd0:    results[k].data = top[23:16];
                    2'd1:    results[k].data = top[15:8];
                    default: results[k].data = top[7:0];
                endcase
            end else if ((3'(k) == {1'b0, cnt}) && res_emit) begin
                results[k].kind = lbte_pkg::KIND_RESIDUE;
                results[k].data = res_byte;
            end else begin
                results[k].kind = lbte_pkg::KIND_COUNT;
                results[k].data = cnt_byte;
            end
        end
    end

endmodule

// File: rtl/core/leading_byte_truncation_encoder.sv
// Leading byte truncation encoder. Each accepted 64-bit sample passes through an
// input register, is encoded combinationally into a list of zero to five result
// bytes held in a result buffer, and the buffer drains one byte per cycle on the
// m_ channel while m_ready is high. A sample with at most one result sustains
// one sample per cycle while m_ready is high; otherwise the next sample waits
// until all its results (up to five) are sent, since that channel moves one
// byte per transfer. A sample that causes no result produces no transfer at all.
// error_exponent resets to -17 and is written through cfg_wr_en/cfg_wr_data;
// the user must write it only while the block is idle; this is not enforced.
// depends on lbte_pkg, lbte_encode and leading_byte_truncation_encoder_defines.svh
`include "leading_byte_truncation_encoder_defines.svh"

module leading_byte_truncation_encoder (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_wr_en,
    input  logic signed [5:0] cfg_wr_data,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [63:0]       s_value_bits,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [1:0]        m_kind,
    output logic [7:0]        m_data_byte,
    output logic              m_last
);

    logic signed [5:0]                     error_exponent_reg;
    logic                                  in_valid_reg;
    logic [63:0]                           in_value_reg;
    lbte_pkg::state_t                      state_reg;
    lbte_pkg::state_t                      state_next;
    lbte_pkg::result_list_t                res_list_reg;
    lbte_pkg::result_list_t                res_list_next;
    logic [lbte_pkg::RES_CNT_W-1:0]        res_n_reg;
    logic [lbte_pkg::RES_CNT_W-1:0]        res_n_next;
    logic [lbte_pkg::RES_CNT_W-1:0]        rd_reg;

    logic out_done;
    logic buf_free;
    logic advance;

    lbte_encode u_encode (
        .value_bits     (in_value_reg),
        .error_exponent (error_exponent_reg),
        .state          (state_reg),
        .state_next     (state_next),
        .results        (res_list_next),
        .result_count   (res_n_next)
    );

    assign m_valid     = rd_reg != res_n_reg;
    assign m_last      = (rd_reg + 1'b1) == res_n_reg;
    assign m_kind      = res_list_reg[rd_reg].kind;
    assign m_data_byte = res_list_reg[rd_reg].data;

    // buffer frees up in the cycle its final transfer completes
    assign out_done = m_valid && m_ready && m_last;
    assign buf_free = !m_valid || out_done;
    assign advance  = in_valid_reg && buf_free;
    assign s_ready  = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            error_exponent_reg <= -6'sd17;
        end else if (cfg_wr_en) begin
            error_exponent_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_value_reg <= s_value_bits;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '0;
            res_n_reg <= '0;
            rd_reg    <= '0;
        end else if (advance) begin
            state_reg <= state_next;
            res_n_reg <= res_n_next;
            rd_reg    <= '0;
        end else if (out_done) begin
            res_n_reg <= '0;
            rd_reg    <= '0;
        end else if (m_valid && m_ready) begin
            rd_reg <= rd_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            res_list_reg <= res_list_next;
        end
    end

    `LBTE_ASSERT_NOW(a_rd_in_range, aclk, aresetn, 1'b1, rd_reg <= res_n_reg, "read index beyond result count")
    `LBTE_ASSERT_NOW(a_n_bounded, aclk, aresetn, 1'b1, res_n_reg <= 3'd5, "result count above five")
    `LBTE_ASSERT_NOW(a_pos_bounded, aclk, aresetn, 1'b1, state_reg.pos <= (lbte_pkg::POS_W)'(lbte_pkg::CHUNK - 1), "chunk position out of range")
    `LBTE_ASSERT_NEXT(a_load_restarts, aclk, aresetn, advance, rd_reg == 3'd0, "buffer load did not restart read index")
    `LBTE_ASSERT_NEXT(a_drain_empties, aclk, aresetn, out_done && !advance, !m_valid, "buffer not empty after final transfer")
    `LBTE_ASSERT_NEXT(a_accept_holds, aclk, aresetn, s_valid && s_ready, in_valid_reg, "accepted sample not registered")

endmodule

// File: tb/tb_top.sv
// self-checking testbench for leading_byte_truncation_encoder
// holds its own model of the encoder in a scoreboard class and needs only lbte_pkg and the rtl
// random idling on both channels, one long receiver hold-off, exponent changed between bursts

typedef struct packed {
    lbte_pkg::kind_t kind;
    logic [7:0]      data;
    logic            last;
} coded_byte_t;

class encoded_stream_scoreboard;
    int           exponent;
    logic [23:0]  prev_top;
    int           position;
    logic [5:0]   count_acc;
    logic [7:0]   residue_acc;
    int           residue_fill;
    coded_byte_t  pending_bytes[$];
    int           failures;

    function new();
        exponent     = -17;
        prev_top     = '0;
        position     = 0;
        count_acc    = '0;
        residue_acc  = '0;
        residue_fill = 0;
        failures     = 0;
    endfunction

    function void set_exponent(logic signed [5:0] e);
        exponent = e;
    endfunction

    // works out the bytes one accepted sample gives and queues them
    function void note_sample(logic [63:0] v);
        logic [23:0]  top;
        logic [7:0]   piece;
        int           req;
        int           kb;
        int           rb;
        int           same;
        int           pos;
        int           grp;
        int unsigned  acc;
        bit           chunk_end;
        coded_byte_t  burst[$];
        top = v[63:40];
        req = 12 - exponent;
        if (req < 0) req = 0;
        if (req > 31) req = 31;
        kb = req / 8;
        rb = req % 8;
        pos = (position >= lbte_pkg::CHUNK) ? 0 : position;

        // leading kept bytes shared with the previous sample, never at a chunk start
        same = 0;
        if (pos != 0) begin
            for (int l = 0; l < kb; l++) begin
                if (prev_top[23-8*l -: 8] != top[23-8*l -: 8]) break;
                same++;
            end
        end
        for (int l = same; l < kb; l++)
            burst.push_back(coded_byte_t'{lbte_pkg::KIND_DATA, top[23-8*l -: 8], 1'b0});

        if (rb != 0) begin
            piece = v[63-8*kb -: 8];
            acc = ({25'd0, residue_acc[6:0]} << rb) | (32'(piece) >> (8 - rb));
            residue_fill += rb;
            if (residue_fill >= 8) begin
                residue_fill -= 8;
                burst.push_back(coded_byte_t'{lbte_pkg::KIND_RESIDUE, 8'(acc >> residue_fill),
                                              1'b0});
                acc &= (32'd1 << residue_fill) - 1;
            end
            residue_acc = 8'(acc);
        end

        grp = pos % 4;
        chunk_end = (pos + 1 >= lbte_pkg::CHUNK);
        acc = ({26'd0, count_acc} << 2) | 32'(kb - same);
        if (grp == 3) begin
            burst.push_back(coded_byte_t'{lbte_pkg::KIND_COUNT, 8'(acc), 1'b0});
            count_acc = '0;
        end else if (chunk_end) begin
            // partial group: unused low pairs stay zero
            burst.push_back(coded_byte_t'{lbte_pkg::KIND_COUNT, 8'(acc << (2 * (3 - grp))),
                                          1'b0});
            count_acc = '0;
        end else begin
            count_acc = 6'(acc);
        end

        prev_top = top;
        position = chunk_end ? 0 : pos + 1;
        if (burst.size() > 0) burst[burst.size()-1].last = 1'b1;
        foreach (burst[i]) pending_bytes.push_back(burst[i]);
    endfunction

    function void check_byte(logic [1:0] kind, logic [7:0] data, logic last);
        coded_byte_t want;
        if (pending_bytes.size() == 0) begin
            $display("%0t: unexpected transfer: kind %0d byte %02h last %0b",
                     $time, kind, data, last);
            failures++;
            return;
        end
        want = pending_bytes.pop_front();
        if (kind !== want.kind) begin
            $display("%0t: kind mismatch: expected %0d, actual %0d", $time, want.kind, kind);
            failures++;
        end
        if (data !== want.data) begin
            $display("%0t: data_byte mismatch: expected %02h, actual %02h",
                     $time, want.data, data);
            failures++;
        end
        if (last !== want.last) begin
            $display("%0t: last mismatch: expected %0b, actual %0b", $time, want.last, last);
            failures++;
        end
    endfunction
endclass

module tb_top;

    localparam int RANDOM_PER_PHASE = 38;
    localparam int DRAIN_CYCLES     = 16;
    localparam int LONG_HOLD        = 300;
    localparam int CYCLE_LIMIT      = 500000;

    // extremes of the legal range, saturating values beyond it and every bit of the field
    localparam int EXPONENT_STEPS [12] = '{4, -19, 12, -32, 31, 11, -4, 0, -20, -1, -9, -17};

    localparam logic [63:0] DIRECTED [15] = '{
        64'h0000_0000_0000_0000, 64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF,
        64'hFFFF_FF00_0000_0000, 64'hFFFE_FF00_0000_0000, 64'hFFFE_FE12_3456_789A,
        64'h7FF0_0000_0000_0000, 64'hFFF0_0000_0000_0000, 64'h7FF8_0000_0000_0001,
        64'h8000_0000_0000_0000, 64'h0000_0000_0000_0001, 64'h3FF0_0000_0000_0000,
        64'h3FF0_0000_0000_0001, 64'h7FEF_FFFF_FFFF_FFFF, 64'h0010_0000_0000_0000
    };

    logic              aclk         = 1'b0;
    logic              aresetn      = 1'b0;
    logic              cfg_wr_en    = 1'b0;
    logic signed [5:0] cfg_wr_data  = '0;
    logic              s_valid      = 1'b0;
    logic              s_ready;
    logic [63:0]       s_value_bits = '0;
    logic              m_valid;
    logic              m_ready      = 1'b0;
    logic [1:0]        m_kind;
    logic [7:0]        m_data_byte;
    logic              m_last;

    bit                idle_on      = 1'b1;
    bit                hold_request = 1'b0;
    int unsigned       cycle_count  = 0;

    encoded_stream_scoreboard sb;

    leading_byte_truncation_encoder u_top (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_value_bits (s_value_bits),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_kind       (m_kind),
        .m_data_byte  (m_data_byte),
        .m_last       (m_last)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("leading_byte_truncation_encoder test failed");
            $finish;
        end
    end

    // mostly no gap, some short ones, a few long
    function automatic int pick_gap();
        int r;
        if (!idle_on) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // mostly samples close to the previous one, so that leading bytes repeat
    function automatic logic [63:0] next_sample(logic [63:0] prev);
        logic [63:0] r;
        r = {$urandom, $urandom};
        case ($urandom_range(0, 9))
            0:       return r;
            1:       return prev;
            2, 3:    return {prev[63:40], r[39:0]};
            4:       return {prev[63:48], r[47:0]};
            5:       return {prev[63:56], r[55:0]};
            6:       return prev ^ (64'd1 << $urandom_range(40, 63));
            7:       return prev + {48'd0, r[15:0]};
            8:       return {r[63], 11'h7FF, r[51:0] & {52{r[0]}}};
            default: return {prev[63:52], r[51:0]};
        endcase
    endfunction

    task automatic send_sample(input logic [63:0] v);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_value_bits <= v;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_sample(v);
    endtask

    // a sample may give no byte at all, so allow the pipe to settle after the last one
    task automatic wait_idle();
        s_valid <= 1'b0;
        while (sb.pending_bytes.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_exponent(input logic signed [5:0] e);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= e;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        sb.set_exponent(e);
    endtask

    initial begin : result_sink
        int stall_left;
        stall_left = 0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready)
                sb.check_byte(m_kind, m_data_byte, m_last);
            if (hold_request) begin
                hold_request = 1'b0;
                stall_left   = LONG_HOLD;
            end else if (stall_left == 0) begin
                stall_left = pick_gap();
            end
            if (stall_left > 0) begin
                m_ready <= 1'b0;
                stall_left--;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    initial begin : stimulus
        logic [63:0] sample;
        sb = new();
        sample = '0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (DIRECTED[i]) begin
            sample = DIRECTED[i];
            send_sample(sample);
        end

        for (int p = 0; p < 12; p++) begin
            wait_idle();
            write_exponent(6'(EXPONENT_STEPS[p]));
            idle_on = (p != 5);
            // receiver stalls long enough for the input side to back up
            if (p == 2) hold_request = 1'b1;
            repeat (RANDOM_PER_PHASE) begin
                sample = next_sample(sample);
                send_sample(sample);
            end
        end

        wait_idle();
        if (sb.failures == 0 && sb.pending_bytes.size() == 0) begin
            $display("leading_byte_truncation_encoder test passed");
        end else begin
            $display("leading_byte_truncation_encoder test failed");
        end
        $finish;
    end

endmodule
